FILE: src/lbs_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lbs_pkg
// Shared types and constants of the linear blend skinning core.
// ----------------------------------------------------------------------------
package lbs_pkg;

  localparam int BONES         = 4;
  localparam int PALETTE_SLOTS = 64;
  localparam int ELEMS         = 12;
  localparam int ROW_W         = $clog2(PALETTE_SLOTS);
  localparam int ELEM_W        = 4;
  localparam int ID_W          = 7;
  localparam int WGT_W         = 16;

  localparam logic [ID_W-1:0] END_MARK = 7'd127;

  localparam logic [7:0] REG_PALETTE_SIZE    = 8'd0;
  localparam logic [7:0] REG_NORMALS_ENABLED = 8'd1;

  // widths of the intermediate terms
  localparam int D_W   = 48;   // clamped position difference
  localparam int DN_W  = 35;   // normal difference
  localparam int CP_W  = 65;   // d * w
  localparam int CN_W  = 52;   // dn * w

  typedef logic signed [31:0]     word_t;
  typedef logic signed [15:0]     half_t;
  typedef logic [WGT_W-1:0]       wgt_t;
  typedef logic signed [CP_W-1:0] cpos_t;
  typedef logic signed [CN_W-1:0] cnrm_t;

  typedef struct packed {
    logic bad;
    logic last;
  } meta_t;

endpackage : lbs_pkg
`default_nettype wire

FILE: src/lbs_lane.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lbs_lane
// One bone lane: private palette copy, matrix products, difference and
// weighting. Four stages behind the read address.
// ----------------------------------------------------------------------------
module lbs_lane (
  input  wire logic                       clk,
  input  wire logic                       en,
  input  wire logic                       wr_en,
  input  wire logic [lbs_pkg::ROW_W-1:0]  wr_row,
  input  wire logic [lbs_pkg::ELEM_W-1:0] wr_elem,
  input  wire lbs_pkg::word_t             wr_data,
  input  wire logic [lbs_pkg::ROW_W-1:0]  rd_row,
  input  wire lbs_pkg::wgt_t              wgt,
  input  wire lbs_pkg::word_t             s1_pos [3],
  input  wire lbs_pkg::half_t             s1_nrm [3],
  input  wire lbs_pkg::word_t             s2_pos [3],
  input  wire lbs_pkg::half_t             s2_nrm [3],
  output lbs_pkg::cpos_t                  cpos [3],
  output lbs_pkg::cnrm_t                  cnrm [3]
);
  import lbs_pkg::*;

  word_t rd [ELEMS];
  wgt_t  w1, w2, w3;

  logic signed [63:0] pp [3][3];
  logic signed [47:0] pn [3][3];
  word_t              tr [3];

  logic signed [D_W-1:0]  d [3];
  logic signed [DN_W-1:0] dn [3];

  logic signed [50:0] dsum [3];
  logic signed [49:0] nsum [3];
  logic signed [D_W-1:0]  dclamp [3];
  logic signed [DN_W-1:0] dnx [3];

  // one bank per matrix element, each read at a single row per cycle while en is high
  for (genvar e = 0; e < ELEMS; e++) begin : g_bank
    word_t bank [PALETTE_SLOTS];
    always_ff @(posedge clk) begin
      if (wr_en && wr_elem == ELEM_W'(e)) begin
        bank[wr_row] <= wr_data;
      end
      if (en) begin
        rd[e] <= bank[rd_row];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      w1 <= wgt;
    end
  end

  // products
  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          pp[r][c] <= 64'(rd[r*4+c]) * 64'(s1_pos[c]);
          pn[r][c] <= 48'(rd[r*4+c]) * 48'(s1_nrm[c]);
        end
        tr[r] <= rd[r*4+3];
      end
      w2 <= w1;
    end
  end

  // differences
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      dsum[r] = 51'(pp[r][0] >>> 16) + 51'(pp[r][1] >>> 16) + 51'(pp[r][2] >>> 16)
              + 51'(tr[r]) - 51'(s2_pos[r]);
      priority if (dsum[r] > 51'sh7FFFFFFFFFFF) begin
        dclamp[r] = {1'b0, {(D_W-1){1'b1}}};
      end else if (dsum[r] < -51'sh800000000000) begin
        dclamp[r] = {1'b1, {(D_W-1){1'b0}}};
      end else begin
        dclamp[r] = dsum[r][D_W-1:0];
      end
      nsum[r] = 50'(pn[r][0]) + 50'(pn[r][1]) + 50'(pn[r][2]);
      dnx[r]  = DN_W'(nsum[r] >>> 16) - DN_W'(s2_nrm[r]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d  <= dclamp;
      dn <= dnx;
      w3 <= w2;
    end
  end

  // weighting
  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < 3; r++) begin
        cpos[r] <= CP_W'(d[r]) * CP_W'($signed({1'b0, w3}));
        cnrm[r] <= CN_W'(dn[r]) * CN_W'($signed({1'b0, w3}));
      end
    end
  end

endmodule : lbs_lane
`default_nettype wire

FILE: src/lbs_merge.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lbs_merge
// Sums the lane contributions onto the rest vertex, saturates and holds the
// result beat in the output register; normals pass unchanged when disabled.
// ----------------------------------------------------------------------------
module lbs_merge (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            en,
  input  wire logic            s4_valid,
  input  wire lbs_pkg::meta_t  s4_meta,
  input  wire logic            nrm_en,
  input  wire lbs_pkg::word_t  s4_pos [3],
  input  wire lbs_pkg::half_t  s4_nrm [3],
  input  wire lbs_pkg::cpos_t  cpos [lbs_pkg::BONES][3],
  input  wire lbs_pkg::cnrm_t  cnrm [lbs_pkg::BONES][3],
  output logic                 out_valid,
  output lbs_pkg::word_t       res_pos [3],
  output lbs_pkg::half_t       res_nrm [3],
  output lbs_pkg::meta_t       res_meta
);
  import lbs_pkg::*;

  logic signed [52:0] psum [3];
  logic signed [39:0] nsum [3];
  word_t pnext [3];
  half_t nnext [3];

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      psum[r] = 53'(s4_pos[r]);
      nsum[r] = 40'(s4_nrm[r]);
      for (int b = 0; b < BONES; b++) begin
        psum[r] = psum[r] + 53'(cpos[b][r] >>> 15);
        nsum[r] = nsum[r] + 40'(cnrm[b][r] >>> 15);
      end
      priority if (psum[r] > 53'sh7FFFFFFF) begin
        pnext[r] = 32'sh7FFFFFFF;
      end else if (psum[r] < -53'sh80000000) begin
        pnext[r] = -32'sh80000000;
      end else begin
        pnext[r] = psum[r][31:0];
      end
      priority if (!nrm_en) begin
        nnext[r] = s4_nrm[r];
      end else if (nsum[r] > 40'sh7FFF) begin
        nnext[r] = 16'sh7FFF;
      end else if (nsum[r] < -40'sh8000) begin
        nnext[r] = -16'sh8000;
      end else begin
        nnext[r] = nsum[r][15:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= s4_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_pos  <= pnext;
      res_nrm  <= nnext;
      res_meta <= s4_meta;
    end
  end

endmodule : lbs_merge
`default_nettype wire

FILE: src/linear_blend_skinning_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// linear_blend_skinning_core
// Four-bone linear blend skinning of positions and normals, Q16.16 / Q1.14.
// ----------------------------------------------------------------------------
// One beat is taken every cycle while no result waits at the output, palette
// writes and vertices alike; a vertex result passes through palette read,
// matrix products, difference, weighting and merge into the output register.
// Each of the four bone lanes keeps its own copy of the palette (64 rows of
// twelve words), so all bones of a vertex are read in the same cycle; a
// palette write updates all copies. The pipeline holds as a whole while a
// result waits at the output.
module linear_blend_skinning_core (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [7:0]          cfg_index,
  input  wire logic [6:0]          cfg_data,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic                kind,
  input  wire logic signed [31:0]  pos_x,
  input  wire logic signed [31:0]  pos_y,
  input  wire logic signed [31:0]  pos_z,
  input  wire logic signed [15:0]  nrm_x,
  input  wire logic signed [15:0]  nrm_y,
  input  wire logic signed [15:0]  nrm_z,
  input  wire logic [27:0]         bone_ids,
  input  wire logic [63:0]         bone_weights,
  input  wire logic [9:0]          palette_address,
  input  wire logic signed [31:0]  palette_value,
  input  wire logic                last_vertex,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic signed [31:0]       out_pos_x,
  output logic signed [31:0]       out_pos_y,
  output logic signed [31:0]       out_pos_z,
  output logic signed [15:0]       out_nrm_x,
  output logic signed [15:0]       out_nrm_y,
  output logic signed [15:0]       out_nrm_z,
  output logic                     bad_bone,
  output logic                     batch_end
);
  import lbs_pkg::*;

  logic [6:0] palette_size;
  logic       normals_enabled;

  logic en, accept;
  logic wr_en;
  logic [7:0]  quad;
  logic [15:0] quot;
  logic [ROW_W-1:0]  wr_row;
  logic [9:0]        rem;
  logic [ELEM_W-1:0] wr_elem;

  logic [ID_W-1:0] id [BONES];
  wgt_t            w  [BONES];
  wgt_t            weff [BONES];
  logic            bad0;

  logic  v1, v2, v3, v4;
  meta_t m1, m2, m3, m4;
  word_t p1 [3], p2 [3], p3 [3], p4 [3];
  half_t n1 [3], n2 [3], n3 [3], n4 [3];
  word_t p0 [3];
  half_t n0 [3];

  cpos_t cpos [BONES][3];
  cnrm_t cnrm [BONES][3];
  word_t res_pos [3];
  half_t res_nrm [3];
  meta_t res_meta;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      palette_size    <= 7'd64;
      normals_enabled <= 1'b1;
    end else if (cfg_valid) begin
      if (cfg_index == REG_PALETTE_SIZE) begin
        palette_size <= cfg_data;
      end
      if (cfg_index == REG_NORMALS_ENABLED) begin
        normals_enabled <= cfg_data[0];
      end
    end
  end

  assign en       = !out_valid || out_ready;
  assign in_ready = en;
  assign accept   = in_valid && in_ready;

  // address / 12: (address / 4) * 171 >> 9 is exact for eight-bit quotients
  assign quad    = palette_address[9:2];
  assign quot    = 16'(quad) * 16'd171;
  assign wr_row  = quot[9 +: ROW_W];
  assign rem     = palette_address - ((10'(wr_row) << 3) + (10'(wr_row) << 2));
  assign wr_elem = rem[ELEM_W-1:0];
  assign wr_en   = accept && !kind && (palette_address < 10'(PALETTE_SLOTS * ELEMS));

  // lane weights: zero for ended, empty or out-of-range bones
  always_comb begin
    logic ended;
    logic oor;
    ended = 1'b0;
    bad0  = 1'b0;
    for (int b = 0; b < BONES; b++) begin
      id[b] = bone_ids[b*ID_W +: ID_W];
      w[b]  = bone_weights[b*WGT_W +: WGT_W];
      if (id[b] == END_MARK) begin
        ended = 1'b1;
      end
      oor = (id[b] >= palette_size) || (id[b] >= ID_W'(PALETTE_SLOTS));
      weff[b] = (!ended && w[b] != '0 && !oor) ? w[b] : '0;
      if (!ended && w[b] != '0 && oor) begin
        bad0 = 1'b1;
      end
    end
  end

  assign p0[0] = pos_x;
  assign p0[1] = pos_y;
  assign p0[2] = pos_z;
  assign n0[0] = nrm_x;
  assign n0[1] = nrm_y;
  assign n0[2] = nrm_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else if (en) begin
      v1 <= accept && kind;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m1 <= '{bad: bad0, last: last_vertex};
      m2 <= m1;
      m3 <= m2;
      m4 <= m3;
      p1 <= p0;
      p2 <= p1;
      p3 <= p2;
      p4 <= p3;
      n1 <= n0;
      n2 <= n1;
      n3 <= n2;
      n4 <= n3;
    end
  end

  for (genvar b = 0; b < BONES; b++) begin : g_lane
    lbs_lane u_lane (
      .clk     (clk),
      .en      (en),
      .wr_en   (wr_en),
      .wr_row  (wr_row),
      .wr_elem (wr_elem),
      .wr_data (palette_value),
      .rd_row  (id[b][ROW_W-1:0]),
      .wgt     (weff[b]),
      .s1_pos  (p1),
      .s1_nrm  (n1),
      .s2_pos  (p2),
      .s2_nrm  (n2),
      .cpos    (cpos[b]),
      .cnrm    (cnrm[b])
    );
  end

  lbs_merge u_merge (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .s4_valid  (v4),
    .s4_meta   (m4),
    .nrm_en    (normals_enabled),
    .s4_pos    (p4),
    .s4_nrm    (n4),
    .cpos      (cpos),
    .cnrm      (cnrm),
    .out_valid (out_valid),
    .res_pos   (res_pos),
    .res_nrm   (res_nrm),
    .res_meta  (res_meta)
  );

  assign out_pos_x = res_pos[0];
  assign out_pos_y = res_pos[1];
  assign out_pos_z = res_pos[2];
  assign out_nrm_x = res_nrm[0];
  assign out_nrm_y = res_nrm[1];
  assign out_nrm_z = res_nrm[2];
  assign bad_bone  = res_meta.bad;
  assign batch_end = res_meta.last;

endmodule : linear_blend_skinning_core
`default_nettype wire

FILE: bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Bench for the linear blend skinning core: fills the bone palette, runs a
// directed table, then random palette and vertex beats over several register
// settings. Each vertex result is checked against a skinning predictor.
// ----------------------------------------------------------------------------
module tb_top;
  import lbs_pkg::*;

  typedef logic signed [127:0] wide_t;

  typedef struct {
    logic        kind;
    word_t       px, py, pz;
    half_t       nx, ny, nz;
    logic [27:0] ids;
    logic [63:0] wts;
    logic [9:0]  addr;
    word_t       val;
    logic        last;
  } beat_t;

  typedef struct packed {
    word_t px, py, pz;
    half_t nx, ny, nz;
    logic  bad;
    logic  last;
  } skin_t;

  typedef enum logic [1:0] {PREDICT, PASS, PASS_BAD} row_chk_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [7:0] cfg_index = '0;
  logic [6:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic kind = 1'b0;
  logic signed [31:0] pos_x = '0, pos_y = '0, pos_z = '0;
  logic signed [15:0] nrm_x = '0, nrm_y = '0, nrm_z = '0;
  logic [27:0] bone_ids = '0;
  logic [63:0] bone_weights = '0;
  logic [9:0] palette_address = '0;
  logic signed [31:0] palette_value = '0;
  logic last_vertex = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [31:0] out_pos_x, out_pos_y, out_pos_z;
  logic signed [15:0] out_nrm_x, out_nrm_y, out_nrm_z;
  logic bad_bone, batch_end;

  linear_blend_skinning_core dut (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  word_t    bone_mem [0:PALETTE_SLOTS*ELEMS-1];
  int       size_reg = 64;
  logic     nrm_reg = 1'b1;
  skin_t    skin_q [$];
  int       errors = 0;
  int       idle_cycles = 0;
  bit       calm = 0;
  beat_t    rows [$];
  row_chk_t row_chk [$];
  row_chk_t cur_chk;

  // Deform one vertex with the current palette and registers.
  function automatic skin_t skin_vertex(beat_t b);
    wide_t p [3];
    wide_t n [3];
    wide_t ap [3];
    wide_t an [3];
    wide_t d, sn, dn, w, m;
    int lim, id, base;
    bit stop;
    skin_t s;
    p[0] = b.px; p[1] = b.py; p[2] = b.pz;
    n[0] = b.nx; n[1] = b.ny; n[2] = b.nz;
    for (int r = 0; r < 3; r++) begin
      ap[r] = p[r];
      an[r] = n[r];
    end
    lim = size_reg < PALETTE_SLOTS ? size_reg : PALETTE_SLOTS;
    stop = 0;
    s.bad = 1'b0;
    for (int k = 0; k < BONES; k++) begin
      id = b.ids[ID_W*k +: ID_W];
      w = b.wts[WGT_W*k +: WGT_W];
      if (id == END_MARK) stop = 1;
      if (!stop && w != 0) begin
        if (id >= lim) begin
          s.bad = 1'b1;
        end else begin
          base = id * ELEMS;
          for (int r = 0; r < 3; r++) begin
            d = 0;
            sn = 0;
            for (int c = 0; c < 3; c++) begin
              m = bone_mem[base + r*4 + c];
              d = d + ((m * p[c]) >>> 16);
              sn = sn + m * n[c];
            end
            m = bone_mem[base + r*4 + 3];
            d = d + m - p[r];
            if (d < -(wide_t'(1) <<< 47)) d = -(wide_t'(1) <<< 47);
            if (d > (wide_t'(1) <<< 47) - 1) d = (wide_t'(1) <<< 47) - 1;
            ap[r] = ap[r] + ((d * w) >>> 15);
            if (nrm_reg) begin
              dn = (sn >>> 16) - n[r];
              an[r] = an[r] + ((dn * w) >>> 15);
            end
          end
        end
      end
    end
    for (int r = 0; r < 3; r++) begin
      if (ap[r] > wide_t'(32'sh7fffffff)) ap[r] = wide_t'(32'sh7fffffff);
      if (ap[r] < wide_t'(32'sh80000000)) ap[r] = wide_t'(32'sh80000000);
      if (an[r] > 32767) an[r] = 32767;
      if (an[r] < -32768) an[r] = -32768;
    end
    s.px = ap[0][31:0]; s.py = ap[1][31:0]; s.pz = ap[2][31:0];
    s.nx = an[0][15:0]; s.ny = an[1][15:0]; s.nz = an[2][15:0];
    s.last = b.last;
    return s;
  endfunction

  function automatic word_t rand_elem(int e);
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return $signed($urandom_range(0, 1 << 18)) - (1 << 17);
      default:
        return ((e == 0 || e == 5 || e == 10) ? 32'sh10000 : 32'sh0)
               + $signed($urandom_range(0, 1 << 14)) - (1 << 13);
    endcase
  endfunction

  function automatic word_t rand_pos();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
      default: return $signed($urandom_range(0, 1 << 24)) - (1 << 23);
    endcase
  endfunction

  function automatic beat_t rand_beat();
    beat_t b;
    int id;
    b.kind = $urandom_range(0, 4) != 0;
    b.px = rand_pos(); b.py = rand_pos(); b.pz = rand_pos();
    b.nx = $urandom; b.ny = $urandom; b.nz = $urandom;
    for (int k = 0; k < BONES; k++) begin
      case ($urandom_range(0, 9))
        0: id = END_MARK;
        1: id = $urandom_range(64, 126);
        default: id = $urandom_range(0, 63);
      endcase
      b.ids[ID_W*k +: ID_W] = id;
      case ($urandom_range(0, 5))
        0: b.wts[WGT_W*k +: WGT_W] = '0;
        1: b.wts[WGT_W*k +: WGT_W] = 16'h8000;
        2: b.wts[WGT_W*k +: WGT_W] = 16'hffff;
        default: b.wts[WGT_W*k +: WGT_W] = $urandom;
      endcase
    end
    b.addr = $urandom_range(0, 9) == 0 ? $urandom_range(768, 1023) : $urandom_range(0, 767);
    b.val = rand_elem(b.addr % ELEMS);
    b.last = $urandom_range(0, 7) == 0;
    return b;
  endfunction

  // Drive one beat and wait until it is taken; book its effect at that edge.
  task automatic send_beat(beat_t b);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    kind <= b.kind;
    pos_x <= b.px; pos_y <= b.py; pos_z <= b.pz;
    nrm_x <= b.nx; nrm_y <= b.ny; nrm_z <= b.nz;
    bone_ids <= b.ids;
    bone_weights <= b.wts;
    palette_address <= b.addr;
    palette_value <= b.val;
    last_vertex <= b.last;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    if (!b.kind) begin
      if (b.addr < PALETTE_SLOTS*ELEMS) bone_mem[b.addr] = b.val;
    end else if (cur_chk == PREDICT) begin
      skin_q.push_back(skin_vertex(b));
    end else begin
      skin_q.push_back('{b.px, b.py, b.pz, b.nx, b.ny, b.nz, cur_chk == PASS_BAD, b.last});
    end
  endtask

  task automatic write_reg(logic [7:0] idx, logic [6:0] data);
    in_valid <= 1'b0;
    wait (skin_q.size() == 0);
    repeat (10) @(posedge clk);
    cfg_index <= idx;
    cfg_data <= data;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == REG_PALETTE_SIZE) size_reg = data;
    else nrm_reg = data[0];
  endtask

  task automatic add_row(row_chk_t chk, logic k, word_t px, word_t py, word_t pz,
                         half_t nx, half_t ny, half_t nz, logic [27:0] ids,
                         logic [63:0] wts, logic [9:0] addr, word_t val);
    beat_t b;
    b = '{k, px, py, pz, nx, ny, nz, ids, wts, addr, val, 1'b1};
    rows.push_back(b);
    row_chk.push_back(chk);
  endtask

  // Check results as they leave; stall the output side at random.
  int stall = 0;
  always @(posedge clk) begin
    skin_t got;
    skin_t want;
    if (!rst) begin
      if (out_valid && out_ready) begin
        got = '{out_pos_x, out_pos_y, out_pos_z, out_nrm_x, out_nrm_y, out_nrm_z,
                bad_bone, batch_end};
        if (skin_q.size() == 0) begin
          $display("%0t: result with none expected: %p", $time, got);
          errors++;
        end else begin
          want = skin_q.pop_front();
          if (got !== want) begin
            $display("%0t: mismatch expected %p actual %p", $time, want, got);
            errors++;
          end
        end
        stall = calm ? 0 : $urandom_range(0, 6);
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        stall--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles == 2000) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    int sizes [8];
    beat_t b;
    sizes = '{64, 1, 0, 127, 64, 7, 33, 64};
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    write_reg(REG_PALETTE_SIZE, 7'd64);
    write_reg(REG_NORMALS_ENABLED, 7'd1);

    // Fill every palette entry: slot 0 identity, slot 1 doubles and adds 3.0 to x, rest random.
    cur_chk = PREDICT;
    for (int a = 0; a < PALETTE_SLOTS*ELEMS; a++) begin
      b = rand_beat();
      b.kind = 1'b0;
      b.addr = a;
      if (a < 24) begin
        b.val = (a % 12 == 0 || a % 12 == 5 || a % 12 == 10) ? (a < 12 ? 32'sh10000 : 32'sh20000) : 0;
        if (a == 15) b.val = 32'sh0003_0000;
      end
      if (a >= 756) b.val = $urandom;
      send_beat(b);
    end

    add_row(PASS, 1, 32'sh7fffffff, 32'sh80000000, 0, 16'sh7fff, 16'sh8000, 0,
            28'd0, 64'd0, 0, 0);
    add_row(PASS, 1, 32'sh12345678, -5, 7, 100, -100, 16'sh4000,
            {4{END_MARK}}, '1, 0, 0);
    add_row(PASS_BAD, 1, 32'sh00010000, 32'sh00020000, -3, 1, 2, 3,
            {END_MARK, END_MARK, END_MARK, 7'd100}, 64'h8000, 0, 0);
    add_row(PASS, 1, 32'sh7fffffff, 32'sh80000000, 32'sh00018000, 16'sh7fff, 16'sh8000, 5,
            {END_MARK, END_MARK, END_MARK, 7'd0}, 64'hffff, 0, 0);
    add_row(PASS, 1, 32'sh00050000, 9, 9, 9, 9, 9,
            {7'd120, 7'd99, 7'd64, 7'd2}, {16'h0, 16'h0, 16'h0, 16'h0}, 0, 0);
    add_row(PREDICT, 1, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 16'sh7fff, 16'sh7fff,
            16'sh7fff, {END_MARK, END_MARK, END_MARK, 7'd1}, 64'h8000, 0, 0);
    add_row(PREDICT, 1, 32'sh80000000, 32'sh80000000, 32'sh80000000, 16'sh8000, 16'sh8000,
            16'sh8000, {END_MARK, END_MARK, END_MARK, 7'd1}, 64'hffff, 0, 0);
    add_row(PREDICT, 1, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 16'sh8000, 16'sh7fff,
            16'sh8000, {7'd3, 7'd2, 7'd1, 7'd0}, '1, 0, 0);
    add_row(PREDICT, 0, 0, 0, 0, 0, 0, 0, 0, 0, 10'd1023, 32'shffffffff);
    add_row(PREDICT, 0, 0, 0, 0, 0, 0, 0, 0, 0, 10'd767, 32'sh80000000);
    add_row(PREDICT, 0, 0, 0, 0, 0, 0, 0, 0, 0, 10'd768, 32'sh7fffffff);
    add_row(PREDICT, 1, -32'sd123456, 32'sh00400000, 32'sh7fffffff, 16'sh8000, 16'sh7fff,
            16'sh1234, {END_MARK, 7'd62, 7'd63, 7'd63}, {16'h0, 16'h1, 16'hffff, 16'h8000},
            0, 0);
    add_row(PREDICT, 1, 32'sh00010000, 32'sh00010000, 32'sh00010000, 16'sh4000, 0, 0,
            {7'd5, END_MARK, 7'd1, 7'd0}, {16'hffff, 16'hffff, 16'h4000, 16'h4000}, 0, 0);
    add_row(PREDICT, 1, 32'sh00010000, -32'sh00010000, 0, 0, 16'sh4000, 0,
            {7'd63, 7'd62, 7'd61, 7'd60}, {4{16'h4000}}, 0, 0);
    foreach (rows[i]) begin
      cur_chk = row_chk[i];
      rows[i].last = i[0];
      send_beat(rows[i]);
    end
    cur_chk = PREDICT;

    for (int ph = 0; ph < 8; ph++) begin
      write_reg(REG_PALETTE_SIZE, sizes[ph]);
      write_reg(REG_NORMALS_ENABLED, (ph == 7) ? $urandom_range(0, 1) : ph[0] ~^ ph[1]);
      for (int i = 0; i < 150; i++) begin
        if ($urandom_range(0, 49) == 0) calm = !calm;
        send_beat(rand_beat());
      end
      calm = 0;
    end

    in_valid <= 1'b0;
    wait (skin_q.size() == 0);
    repeat (20) @(posedge clk);
    if (errors == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
